### rtl/core/wrfd_pkg.sv
// Shared types, codes and BCD helper functions for the weather record field decoder.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps
package wrfd_pkg;

  // result queue sizing
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // record positions that produce results
  localparam logic [4:0] PosUv    = 5'd19;
  localparam logic [4:0] PosPress = 5'd21;
  localparam logic [4:0] PosStorm = 5'd22;
  localparam logic [4:0] PosChill = 5'd24;
  localparam logic [4:0] PosGust  = 5'd26;
  localparam logic [4:0] PosSpeed = 5'd28;
  localparam logic [4:0] PosDir   = 5'd29;
  localparam logic [4:0] PosRain  = 5'd31;

  // special byte patterns
  localparam logic [7:0] PatNoUvHi   = 8'hAA;
  localparam logic [7:0] PatNoUvLo   = 8'h0A;
  localparam logic [7:0] PatInvLo    = 8'hAA;
  localparam logic [7:0] PatInvHi    = 8'h8A;
  localparam logic [7:0] PatLinkLo   = 8'hBB;
  localparam logic [7:0] PatLinkHi   = 8'h8B;
  localparam logic [7:0] PatErrLo    = 8'hEE;
  localparam logic [7:0] PatErrHi    = 8'h8E;
  localparam logic [3:0] NibNoLinkB  = 4'hB;
  localparam logic [3:0] NibNoLinkC  = 4'hC;
  localparam logic [3:0] NibAbsent   = 4'hF;

  // mph tenths to m/s hundredths: (t * WindScale) >> WindShift
  localparam logic [25:0] WindScale = 26'd18311;
  localparam int          WindShift = 12;

  typedef enum logic [3:0] {
    Q_TEMP     = 4'd0,
    Q_HUMID    = 4'd1,
    Q_UV       = 4'd2,
    Q_PRESS    = 4'd3,
    Q_STORM    = 4'd4,
    Q_FORECAST = 4'd5,
    Q_CHILL    = 4'd6,
    Q_GUST     = 4'd7,
    Q_SPEED    = 4'd8,
    Q_DIR      = 4'd9,
    Q_RAIN     = 4'd10
  } quantity_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_NOLINK  = 3'd2,
    ST_ERROR   = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  typedef struct packed {
    quantity_t          quantity;
    logic [2:0]         channel;
    logic signed [16:0] value;
    status_t            status;
    logic               last;
  } result_t;

  typedef struct packed {
    result_t    first;
    result_t    second;
    logic [1:0] count;
    logic       gust_we;
    logic       speed_we;
    status_t    wind_status;
  } decode_out_t;

  // both nibbles widened first; non-BCD input reaches 165 at most
  function automatic logic [7:0] bcd_val(input logic [7:0] b);
    bcd_val = ({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
  endfunction

  function automatic logic not_bcd(input logic [7:0] b);
    not_bcd = (b[7:4] > 4'd9) || (b[3:0] > 4'd9);
  endfunction

  // signed hundredths from a BCD low byte and a sign/flag/tens byte
  function automatic logic signed [16:0] signed_hundredths(input logic [7:0] lo,
                                                           input logic [7:0] hi);
    logic [16:0] mag;
    mag = 17'({9'd0, bcd_val(lo)} * 17'd10) + 17'({13'd0, hi[3:0]} * 17'd1000)
          + (hi[5] ? 17'd5 : 17'd0);
    signed_hundredths = hi[7] ? $signed(mag) : -$signed(mag);
  endfunction

endpackage

### rtl/core/wrfd_decode.sv
// Combinational field decoder: one record byte plus held context in, up to two results out.
// Depends on wrfd_pkg.
`timescale 1ns / 1ps
module wrfd_decode (
  input  logic [4:0]            pos,
  input  logic [7:0]            cur_byte,
  input  logic [7:0]            older_byte,
  input  logic [7:0]            newer_byte,
  input  wrfd_pkg::status_t     gust_status,
  input  wrfd_pkg::status_t     speed_status,
  output wrfd_pkg::decode_out_t dec
);
  import wrfd_pkg::*;

  logic [2:0]         ch;
  status_t            ts, hs, uv_st, chill_st, wind_st;
  logic signed [16:0] tv, hv, uv_v, chill_v, wind_v;
  logic [11:0]        wind_t;
  logic [25:0]        wind_p;

  always_comb begin
    case (pos)
      5'd5:    ch = 3'd1;
      5'd8:    ch = 3'd2;
      5'd11:   ch = 3'd3;
      5'd14:   ch = 3'd4;
      5'd17:   ch = 3'd5;
      default: ch = 3'd0;
    endcase
  end

  // temperature / humidity pair
  always_comb begin
    ts = ST_OK;
    if (older_byte[3:0] > 4'd9) begin
      ts = (older_byte[3:0] == NibNoLinkC || older_byte[3:0] == NibNoLinkB) ?
           ST_NOLINK : ST_INVALID;
    end
    if (!newer_byte[6] && ch != 3'd0) ts = ST_NOLINK;
    tv = (ts == ST_OK) ? signed_hundredths(older_byte, newer_byte) : 17'sd0;
    hv = 17'sd0;
    if (ts == ST_NOLINK) hs = ST_NOLINK;
    else if (cur_byte[3:0] > 4'd9) hs = ST_ERROR;
    else begin
      hs = ST_OK;
      hv = $signed({9'd0, bcd_val(cur_byte)});
    end
  end

  // UV
  always_comb begin
    uv_v = 17'sd0;
    if (newer_byte == PatNoUvHi && cur_byte == PatNoUvLo) uv_st = ST_ERROR;
    else if (bcd_val(newer_byte) > 8'd99 || bcd_val(cur_byte) > 8'd99) uv_st = ST_INVALID;
    else begin
      uv_st = ST_OK;
      uv_v  = $signed(17'(newer_byte[3:0]) + 17'({13'd0, newer_byte[7:4]} * 17'd100)
                      + 17'({13'd0, cur_byte[3:0]} * 17'd100));
    end
  end

  // windchill
  always_comb begin
    chill_st = ST_OK;
    if (not_bcd(newer_byte)) begin
      if (newer_byte == PatInvLo && cur_byte == PatInvHi) chill_st = ST_INVALID;
      else if (newer_byte == PatLinkLo && cur_byte == PatLinkHi) chill_st = ST_NOLINK;
      else if (newer_byte == PatErrLo && cur_byte == PatErrHi) chill_st = ST_ERROR;
      else chill_st = ST_UNKNOWN;
    end
    if (!cur_byte[6]) chill_st = ST_NOLINK;
    chill_v = (chill_st == ST_OK) ? signed_hundredths(newer_byte, cur_byte) : 17'sd0;
  end

  // gust / speed share one converter
  always_comb begin
    wind_t = 12'(bcd_val(newer_byte)) + 12'({8'd0, cur_byte[3:0]} * 12'd100)
             + (cur_byte[4] ? 12'd1000 : 12'd0);
    wind_p = 26'(wind_t) * WindScale;
    wind_v = 17'sd0;
    if (not_bcd(newer_byte)) begin
      if (newer_byte == PatLinkLo && cur_byte == PatLinkHi) wind_st = ST_NOLINK;
      else if (newer_byte == PatErrLo && cur_byte == PatErrHi) wind_st = ST_ERROR;
      else wind_st = ST_UNKNOWN;
    end else begin
      wind_st = ST_OK;
      wind_v  = $signed({3'd0, wind_p[25:WindShift]});
    end
  end

  always_comb begin
    dec             = '0;
    dec.wind_status = wind_st;
    unique case (pos) inside
      5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17: begin
        dec.first  = '{quantity: Q_TEMP, channel: ch, value: tv, status: ts, last: 1'b0};
        dec.second = '{quantity: Q_HUMID, channel: ch, value: hv, status: hs, last: 1'b1};
        dec.count  = 2'd2;
      end
      PosUv: begin
        dec.first = '{quantity: Q_UV, channel: 3'd0, value: uv_v, status: uv_st, last: 1'b1};
        dec.count = 2'd1;
      end
      PosPress: begin
        dec.first.quantity = Q_PRESS;
        dec.first.last     = 1'b1;
        if (cur_byte[7:4] == NibAbsent) dec.first.status = ST_INVALID;
        else dec.first.value = $signed({1'b0, cur_byte, newer_byte});
        dec.count = 2'd1;
      end
      PosStorm: begin
        dec.first.quantity  = Q_STORM;
        dec.second.quantity = Q_FORECAST;
        dec.second.last     = 1'b1;
        if (cur_byte[3:0] == NibAbsent) begin
          dec.first.status  = ST_INVALID;
          dec.second.status = ST_INVALID;
        end else begin
          dec.first.value  = $signed({16'd0, cur_byte[3]});
          dec.second.value = $signed({14'd0, cur_byte[2:0]});
        end
        dec.count = 2'd2;
      end
      PosChill: begin
        dec.first = '{quantity: Q_CHILL, channel: 3'd0, value: chill_v, status: chill_st,
                      last: 1'b1};
        dec.count = 2'd1;
      end
      PosGust: begin
        dec.first = '{quantity: Q_GUST, channel: 3'd0, value: wind_v, status: wind_st,
                      last: 1'b1};
        dec.gust_we = 1'b1;
        dec.count   = 2'd1;
      end
      PosSpeed: begin
        dec.first = '{quantity: Q_SPEED, channel: 3'd0, value: wind_v, status: wind_st,
                      last: 1'b1};
        dec.speed_we = 1'b1;
        dec.count    = 2'd1;
      end
      PosDir: begin
        dec.first.quantity = Q_DIR;
        dec.first.last     = 1'b1;
        if (gust_status >= ST_ERROR || speed_status >= ST_ERROR) dec.first.status = ST_ERROR;
        else dec.first.value = $signed({13'd0, cur_byte[3:0]});
        dec.count = 2'd1;
      end
      PosRain: begin
        dec.first.quantity = Q_RAIN;
        dec.first.last     = 1'b1;
        dec.first.value    = $signed({1'b0, cur_byte, newer_byte});
        dec.count          = 2'd1;
      end
      default: dec.count = 2'd0;
    endcase
  end

endmodule

### rtl/core/wrfd_result_queue.sv
// Small result queue: takes zero to two results per cycle, hands out one.
// Depends on wrfd_pkg.
`timescale 1ns / 1ps
module wrfd_result_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  push_n,
  input  wrfd_pkg::result_t           push_a,
  input  wrfd_pkg::result_t           push_b,
  input  logic                        pop,
  output wrfd_pkg::result_t           head,
  output logic [wrfd_pkg::QCntW-1:0]  count
);
  import wrfd_pkg::*;

  result_t          mem [QueueDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QPtrW-1:0] wr_ptr_b;

  assign wr_ptr_b = wr_ptr + QPtrW'(1);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPtrW'(push_n);
      rd_ptr <= rd_ptr + QPtrW'(pop);
      count  <= count + QCntW'(push_n) - QCntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr] <= push_a;
    if (push_n == 2'd2) mem[wr_ptr_b] <= push_b;
  end

endmodule

### rtl/core/weather_record_field_decoder_unit.sv
// Top level of the weather record field decoder: input register, record state, queue.
// Depends on wrfd_pkg, wrfd_decode and wrfd_result_queue.
`timescale 1ns / 1ps
// A 32-byte packed-BCD weather record enters one byte per item on the input
// channel; start_of_record forces the byte to record position 0, otherwise the
// position counts up and wraps after 31. Bytes that close a field produce one
// or two result items (temperature then humidity for each of six channels,
// storm then forecast) carrying quantity, channel, value, status and a
// last_of_step mark on the final item of that byte; other bytes produce none.
// Each byte is held in the input register, decoded combinationally and written
// into a 4-entry result queue once it has room for two results; the first
// result is presented at the queue head as soon as that write is done.
// Input bytes are taken one per cycle while the queue has room for
// two results; the sustained rate is therefore one byte per cycle while the
// receiver holds out_ready high, limited only by the single output port, which moves
// one result item per cycle (a two-result byte uses it for each of its results).
module weather_record_field_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  record_byte,
  input  logic        start_of_record,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  quantity,
  output logic [2:0]  channel,
  output logic signed [16:0] value,
  output logic [2:0]  status,
  output logic        last_of_step
);
  import wrfd_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       s1_adv;

  // record context
  logic [4:0] position;
  logic [7:0] older_byte;
  logic [7:0] newer_byte;
  status_t    gust_status;
  status_t    speed_status;
  logic [4:0] pos_eff;

  decode_out_t      dec;
  result_t          head;
  logic [QCntW-1:0] q_count;
  logic [1:0]       push_n;
  logic             pop;

  // room for a worst-case byte (two results) regardless of a pop this cycle
  assign s1_adv   = s1_valid && (q_count <= QCntW'(QueueDepth - 2));
  assign in_ready = !s1_valid || s1_adv;
  assign pos_eff  = s1_start ? 5'd0 : position;
  assign push_n   = s1_adv ? dec.count : 2'd0;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (in_ready) s1_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= record_byte;
      s1_start <= start_of_record;
    end
  end

  // record state moves only when the registered byte is decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      older_byte   <= '0;
      newer_byte   <= '0;
      gust_status  <= ST_OK;
      speed_status <= ST_OK;
    end else if (s1_adv) begin
      position   <= pos_eff + 5'd1;
      older_byte <= newer_byte;
      newer_byte <= s1_byte;
      if (dec.gust_we) gust_status <= dec.wind_status;
      if (dec.speed_we) speed_status <= dec.wind_status;
    end
  end

  wrfd_decode u_decode (
    .pos          (pos_eff),
    .cur_byte     (s1_byte),
    .older_byte   (older_byte),
    .newer_byte   (newer_byte),
    .gust_status  (gust_status),
    .speed_status (speed_status),
    .dec          (dec)
  );

  wrfd_result_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .push_a (dec.first),
    .push_b (dec.second),
    .pop    (pop),
    .head   (head),
    .count  (q_count)
  );

  assign out_valid    = (q_count != '0);
  assign quantity     = head.quantity;
  assign channel      = head.channel;
  assign value        = head.value;
  assign status       = head.status;
  assign last_of_step = head.last;

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCntW'(QueueDepth))
    else $error("result queue over capacity");

  // position steps by one from the effective position of each decoded byte
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> position == 5'($past(pos_eff) + 5'd1))
    else $error("record position did not advance");

  // a two-result byte marks only its second result as last
  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && dec.count == 2'd2) |-> (!dec.first.last && dec.second.last))
    else $error("last_of_step misplaced in result pair");

  // an error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> value == 17'sd0)
    else $error("nonzero value with error status");

endmodule

### sim/weather_record_field_decoder_unit_tb.sv
// Self-checking testbench for weather_record_field_decoder_unit: directed record table,
// then shaped random records under four handshake idle mixes and one long output hold.
// Depends on wrfd_pkg and the decoder RTL; needs no other files.
`timescale 1ns / 1ps
module weather_record_field_decoder_unit_tb;
  import wrfd_pkg::*;

  localparam int QuietLimit = 3000; // cycles with no transfer on either channel
  localparam int HoldLen    = 400;  // long output hold, fills the result queue
  localparam int PhaseBytes = 300;  // bytes per idle mix
  localparam int DrainWait  = 8;

  // one expected result
  typedef struct packed {
    quantity_t          q;
    logic [2:0]         ch;
    logic signed [16:0] v;
    status_t            st;
    logic               last;
  } reading_t;

  // directed row: nexp = 0 means the predictor supplies the results
  typedef struct packed {
    logic [7:0] b;
    logic       s;
    logic [1:0] nexp;
    reading_t   r0;
    reading_t   r1;
  } stim_row_t;

  localparam reading_t NoRd = '0;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] record_byte = 8'h00;
  logic start_of_record = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] quantity;
  logic [2:0] channel;
  logic signed [16:0] value;
  logic [2:0] status;
  logic last_of_step;

  // typed expectations travel with the item they belong to
  logic [1:0] row_nexp = 2'd0;
  reading_t   row_r0 = '0;
  reading_t   row_r1 = '0;

  // predictor state
  logic [4:0] rec_pos = 5'd0;
  logic [7:0] prev2_byte = 8'h00;
  logic [7:0] prev1_byte = 8'h00;
  status_t    gust_st = ST_OK;
  status_t    speed_st = ST_OK;

  reading_t   pending_readings [$];
  int         mismatches = 0;
  int         readings_seen = 0;
  int         bytes_taken = 0;
  int         bytes_offered = 0;
  int         records_sent = 0;
  logic [4:0] gen_pos = 5'd0;
  int         send_idle_pct = 0;
  int         sink_stall_pct = 0;
  int         hold_gen = 0;
  int         quiet = 0;

  weather_record_field_decoder_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .record_byte     (record_byte),
    .start_of_record (start_of_record),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .quantity        (quantity),
    .channel         (channel),
    .value           (value),
    .status          (status),
    .last_of_step    (last_of_step)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic reading_t rd(quantity_t q, int ch, int v, status_t st, logic last);
    reading_t r;
    r.q = q;
    r.ch = 3'(ch);
    r.v = 17'(v);
    r.st = st;
    r.last = last;
    return r;
  endfunction

  function automatic stim_row_t row(logic [7:0] b, logic s, logic [1:0] nexp,
                                    reading_t r0, reading_t r1);
    stim_row_t t;
    t.b = b;
    t.s = s;
    t.nexp = nexp;
    t.r0 = r0;
    t.r1 = r1;
    return t;
  endfunction

  function automatic int bcd2int(logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic logic is_bcd(logic [7:0] b);
    return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
  endfunction

  // bit 7 = sign (set is positive), bit 5 = +0.05, low nibble = tens (thousands of hundredths)
  function automatic int hundredths(logic [7:0] lo, logic [7:0] hi);
    int m;
    m = bcd2int(lo) * 10 + int'(hi[3:0]) * 1000 + (hi[5] ? 5 : 0);
    return hi[7] ? m : -m;
  endfunction

  // wind in mph tenths -> m/s hundredths, truncated
  function automatic status_t wind_level(logic [7:0] lo, logic [7:0] hi, output int v);
    int t;
    v = 0;
    if (!is_bcd(lo)) begin
      if (lo == PatLinkLo && hi == PatLinkHi) return ST_NOLINK;
      if (lo == PatErrLo && hi == PatErrHi) return ST_ERROR;
      return ST_UNKNOWN;
    end
    t = bcd2int(lo) + int'(hi[3:0]) * 100 + (hi[4] ? 1000 : 0);
    v = (t * int'(WindScale)) >>> WindShift;
    return ST_OK;
  endfunction

  // decodes one accepted byte, advancing the record state
  function automatic void decode_byte(logic [7:0] b, logic sor, output int n,
                                      output reading_t r0, output reading_t r1);
    logic [4:0] p;
    logic [7:0] o;
    logic [7:0] w;
    status_t ts;
    status_t hs;
    status_t st;
    int v;
    int hv;
    o = prev2_byte;
    w = prev1_byte;
    n = 0;
    r0 = '0;
    r1 = '0;
    v = 0;
    hv = 0;
    if (sor) rec_pos = 5'd0;
    p = rec_pos;
    if (p <= 5'd17 && (p % 3) == 2) begin
      ts = ST_OK;
      if (o[3:0] > 4'd9) begin
        ts = (o[3:0] == NibNoLinkB || o[3:0] == NibNoLinkC) ? ST_NOLINK : ST_INVALID;
      end
      if (!w[6] && p / 3 > 0) ts = ST_NOLINK;
      if (ts == ST_OK) v = hundredths(o, w);
      if (ts == ST_NOLINK) hs = ST_NOLINK;
      else if (b[3:0] > 4'd9) hs = ST_ERROR;
      else begin
        hs = ST_OK;
        hv = bcd2int(b);
      end
      r0 = rd(Q_TEMP, p / 3, v, ts, 1'b0);
      r1 = rd(Q_HUMID, p / 3, hv, hs, 1'b1);
      n = 2;
    end else begin
      case (p)
        PosUv: begin
          if (w == PatNoUvHi && b == PatNoUvLo) st = ST_ERROR;
          else if (bcd2int(w) > 99 || bcd2int(b) > 99) st = ST_INVALID;
          else begin
            st = ST_OK;
            v = int'(w[3:0]) + int'(w[7:4]) * 100 + int'(b[3:0]) * 100;
          end
          r0 = rd(Q_UV, 0, v, st, 1'b1);
          n = 1;
        end
        PosPress: begin
          if (b[7:4] == NibAbsent) r0 = rd(Q_PRESS, 0, 0, ST_INVALID, 1'b1);
          else r0 = rd(Q_PRESS, 0, int'(b) * 256 + int'(w), ST_OK, 1'b1);
          n = 1;
        end
        PosStorm: begin
          if (b[3:0] == NibAbsent) begin
            r0 = rd(Q_STORM, 0, 0, ST_INVALID, 1'b0);
            r1 = rd(Q_FORECAST, 0, 0, ST_INVALID, 1'b1);
          end else begin
            r0 = rd(Q_STORM, 0, int'(b[3]), ST_OK, 1'b0);
            r1 = rd(Q_FORECAST, 0, int'(b[2:0]), ST_OK, 1'b1);
          end
          n = 2;
        end
        PosChill: begin
          st = ST_OK;
          if (!is_bcd(w)) begin
            if (w == PatInvLo && b == PatInvHi) st = ST_INVALID;
            else if (w == PatLinkLo && b == PatLinkHi) st = ST_NOLINK;
            else if (w == PatErrLo && b == PatErrHi) st = ST_ERROR;
            else st = ST_UNKNOWN;
          end
          if (!b[6]) st = ST_NOLINK;
          if (st == ST_OK) v = hundredths(w, b);
          r0 = rd(Q_CHILL, 0, v, st, 1'b1);
          n = 1;
        end
        PosGust: begin
          gust_st = wind_level(w, b, v);
          r0 = rd(Q_GUST, 0, v, gust_st, 1'b1);
          n = 1;
        end
        PosSpeed: begin
          speed_st = wind_level(w, b, v);
          r0 = rd(Q_SPEED, 0, v, speed_st, 1'b1);
          n = 1;
        end
        PosDir: begin
          if (gust_st >= ST_ERROR || speed_st >= ST_ERROR) r0 = rd(Q_DIR, 0, 0, ST_ERROR, 1'b1);
          else r0 = rd(Q_DIR, 0, int'(b[3:0]), ST_OK, 1'b1);
          n = 1;
        end
        PosRain: begin
          r0 = rd(Q_RAIN, 0, int'(b) * 256 + int'(w), ST_OK, 1'b1);
          n = 1;
        end
        default: n = 0;
      endcase
    end
    prev2_byte = prev1_byte;
    prev1_byte = b;
    rec_pos = p + 5'd1;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 30) begin
      $display("[%0t] result %0d: %s got %0d want %0d", $realtime, readings_seen, what, got,
               want);
    end
  endtask

  // result side: check against the oldest expectation; byte side: predict
  always @(posedge clk) begin : monitor
    int n;
    reading_t p0;
    reading_t p1;
    reading_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_readings.size() == 0) begin
          flag_mismatch("result with nothing pending, quantity", int'(quantity), -1);
        end else begin
          e = pending_readings.pop_front();
          if (quantity != e.q) flag_mismatch("quantity", int'(quantity), int'(e.q));
          if (channel != e.ch) flag_mismatch("channel", int'(channel), int'(e.ch));
          if (value != e.v) flag_mismatch("value", int'($signed(value)), int'($signed(e.v)));
          if (status != e.st) flag_mismatch("status", int'(status), int'(e.st));
          if (last_of_step != e.last) flag_mismatch("last_of_step", last_of_step, e.last);
        end
        readings_seen++;
      end
      if (in_valid && in_ready) begin
        decode_byte(record_byte, start_of_record, n, p0, p1);
        if (row_nexp != 2'd0) begin
          n = row_nexp;
          p0 = row_r0;
          p1 = row_r1;
        end
        if (n > 0) pending_readings.push_back(p0);
        if (n > 1) pending_readings.push_back(p1);
        bytes_taken++;
      end
    end
  end

  // no progress on either channel for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("watchdog: %0d cycles without a transfer, %0d results pending", quiet,
                 pending_readings.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result receiver: random stalls, plus a long hold whenever hold_gen moves
  initial begin : sink
    int seen;
    int left;
    seen = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_gen != seen) begin
        seen = hold_gen;
        left = HoldLen;
      end
      if (left > 0) begin
        left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // offer one byte after a random idle gap; returns at the accepting edge
  task automatic send_byte(logic [7:0] b, logic s, logic [1:0] nexp, reading_t r0,
                           reading_t r1);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    record_byte <= b;
    start_of_record <= s;
    row_nexp <= nexp;
    row_r0 <= r0;
    row_r1 <= r1;
    do @(posedge clk); while (!in_ready);
    gen_pos = s ? 5'd1 : gen_pos + 5'd1;
    bytes_offered++;
  endtask

  function automatic logic [7:0] bcd_byte();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // byte content that mostly suits the field at this record position
  function automatic logic [7:0] shaped_byte(logic [4:0] pos, logic [7:0] prev);
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    b = 8'($urandom_range(0, 255));
    if (r < 8) return b;
    if (pos <= 5'd17) begin
      case (pos % 3)
        0: if (r < 80) b = bcd_byte(); else b[3:0] = 4'($urandom_range(10, 15));
        1: if (r < 88) b[6] = 1'b1;
        default: if (r < 85) b = bcd_byte();
      endcase
    end else begin
      case (pos)
        PosUv - 5'd1: begin
          if (r < 25) b = PatNoUvHi;
          else if (r < 85) b = bcd_byte();
        end
        PosUv: begin
          if (prev == PatNoUvHi && r < 70) b = PatNoUvLo;
          else if (r < 85) b = bcd_byte();
        end
        PosPress: if (r < 25) b[7:4] = NibAbsent;
        PosStorm: if (r < 25) b[3:0] = NibAbsent;
        PosChill - 5'd1, PosGust - 5'd1, PosSpeed - 5'd1: begin
          if (r < 35) begin
            case ($urandom_range(0, 2))
              0: b = PatInvLo;
              1: b = PatLinkLo;
              default: b = PatErrLo;
            endcase
          end else if (r < 85) b = bcd_byte();
        end
        PosChill, PosGust, PosSpeed: begin
          if ((prev == PatInvLo || prev == PatLinkLo || prev == PatErrLo) && r < 70) begin
            b = (prev == PatInvLo) ? PatInvHi : (prev == PatLinkLo) ? PatLinkHi : PatErrHi;
          end else if (pos == PosChill && r < 88) b[6] = 1'b1;
        end
        default: ;
      endcase
    end
    return b;
  endfunction

  // mostly whole records from a start flag; some cut short or left to wrap
  task automatic send_random_record();
    int len;
    bit with_start;
    logic [7:0] b;
    logic [7:0] prev;
    with_start = ($urandom_range(0, 9) != 0);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 31) : 32;
    prev = 8'h00;
    for (int i = 0; i < len; i++) begin
      if (i == 0 && with_start) gen_pos = 5'd0;
      b = shaped_byte(gen_pos, prev);
      send_byte(b, i == 0 && with_start, 2'd0, NoRd, NoRd);
      prev = b;
    end
    records_sent++;
  endtask

  initial begin : stimulus
    stim_row_t dir_tbl [$];
    int phase_start;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one full record with error patterns on most fields, then wrap and resync
    dir_tbl.push_back(row(8'h99, 1'b1, 2'd0, NoRd, NoRd));
    dir_tbl.push_back(row(8'hA9, 1'b0, 2'd0, NoRd, NoRd)); // ch0 ignores the link bit
    dir_tbl.push_back(row(8'h99, 1'b0, 2'd2, rd(Q_TEMP, 0, 9995, ST_OK, 1'b0),
                          rd(Q_HUMID, 0, 99, ST_OK, 1'b1)));
    dir_tbl.push_back(row(8'h0B, 1'b0, 2'd0, NoRd, NoRd)); // no-link nibble
    dir_tbl.push_back(row(8'hC0, 1'b0, 2'd0, NoRd, NoRd));
    dir_tbl.push_back(row(8'h50, 1'b0, 2'd2, rd(Q_TEMP, 1, 0, ST_NOLINK, 1'b0),
                          rd(Q_HUMID, 1, 0, ST_NOLINK, 1'b1)));
    dir_tbl.push_back(row(8'h0F, 1'b0, 2'd0, NoRd, NoRd)); // invalid nibble
    dir_tbl.push_back(row(8'h40, 1'b0, 2'd0, NoRd, NoRd));
    dir_tbl.push_back(row(8'h3A, 1'b0, 2'd2, rd(Q_TEMP, 2, 0, ST_INVALID, 1'b0),
                          rd(Q_HUMID, 2, 0, ST_ERROR, 1'b1)));
    dir_tbl.push_back(row(8'h12, 1'b0, 2'd0, NoRd, NoRd));
    dir_tbl.push_back(row(8'h80, 1'b0, 2'd0, NoRd, NoRd)); // link bit clear
    dir_tbl.push_back(row(8'h00, 1'b0, 2'd2, rd(Q_TEMP, 3, 0, ST_NOLINK, 1'b0),
                          rd(Q_HUMID, 3, 0, ST_NOLINK, 1'b1)));
    dir_tbl.push_back(row(8'h00, 1'b0, 2'd0, NoRd, NoRd));
    dir_tbl.push_back(row(8'h40, 1'b0, 2'd0, NoRd, NoRd)); // negative zero
    dir_tbl.push_back(row(8'h00, 1'b0, 2'd2, rd(Q_TEMP, 4, 0, ST_OK, 1'b0),
                          rd(Q_HUMID, 4, 0, ST_OK, 1'b1)));
    dir_tbl.push_back(row(8'h37, 1'b0, 2'd0, NoRd, NoRd));
    dir_tbl.push_back(row(8'h62, 1'b0, 2'd0, NoRd, NoRd));
    dir_tbl.push_back(row(8'h0C, 1'b0, 2'd0, NoRd, NoRd));
    dir_tbl.push_back(row(PatNoUvHi, 1'b0, 2'd0, NoRd, NoRd));
    dir_tbl.push_back(row(PatNoUvLo, 1'b0, 2'd1, rd(Q_UV, 0, 0, ST_ERROR, 1'b1), NoRd));
    dir_tbl.push_back(row(8'hFF, 1'b0, 2'd0, NoRd, NoRd));
    dir_tbl.push_back(row(8'hF0, 1'b0, 2'd1, rd(Q_PRESS, 0, 0, ST_INVALID, 1'b1), NoRd));
    dir_tbl.push_back(row(8'h0F, 1'b0, 2'd2, rd(Q_STORM, 0, 0, ST_INVALID, 1'b0),
                          rd(Q_FORECAST, 0, 0, ST_INVALID, 1'b1)));
    dir_tbl.push_back(row(8'hA5, 1'b0, 2'd0, NoRd, NoRd)); // unknown chill pattern
    dir_tbl.push_back(row(8'hC1, 1'b0, 2'd1, rd(Q_CHILL, 0, 0, ST_UNKNOWN, 1'b1), NoRd));
    dir_tbl.push_back(row(PatErrLo, 1'b0, 2'd0, NoRd, NoRd));
    dir_tbl.push_back(row(PatErrHi, 1'b0, 2'd1, rd(Q_GUST, 0, 0, ST_ERROR, 1'b1), NoRd));
    dir_tbl.push_back(row(8'h99, 1'b0, 2'd0, NoRd, NoRd)); // fastest wind
    dir_tbl.push_back(row(8'h1F, 1'b0, 2'd0, NoRd, NoRd));
    dir_tbl.push_back(row(8'h07, 1'b0, 2'd1, rd(Q_DIR, 0, 0, ST_ERROR, 1'b1), NoRd));
    dir_tbl.push_back(row(8'hFF, 1'b0, 2'd0, NoRd, NoRd));
    dir_tbl.push_back(row(8'hFF, 1'b0, 2'd1, rd(Q_RAIN, 0, 65535, ST_OK, 1'b1), NoRd));
    dir_tbl.push_back(row(8'h55, 1'b0, 2'd0, NoRd, NoRd)); // wraps to position 0
    dir_tbl.push_back(row(8'h12, 1'b1, 2'd0, NoRd, NoRd)); // resync one byte in
    dir_tbl.push_back(row(8'hC9, 1'b0, 2'd0, NoRd, NoRd));
    dir_tbl.push_back(row(8'h47, 1'b0, 2'd0, NoRd, NoRd));
    foreach (dir_tbl[i]) begin
      send_byte(dir_tbl[i].b, dir_tbl[i].s, dir_tbl[i].nexp, dir_tbl[i].r0, dir_tbl[i].r1);
    end

    // random part: back to back with a long output hold, then the idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  hold_gen++; end
        1: begin send_idle_pct = 65; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 65; end
        default: begin send_idle_pct = 30; sink_stall_pct = 30; end
      endcase
      phase_start = bytes_offered;
      while (bytes_offered - phase_start < PhaseBytes) begin
        if ($urandom_range(0, 15) == 0) begin
          repeat ($urandom_range(1, 5)) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 2'd0, NoRd, NoRd);
          end
        end else begin
          send_random_record();
        end
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (pending_readings.size() != 0) begin
      flag_mismatch("results never produced", 0, pending_readings.size());
    end

    $display("run covered %0d bytes (%0d directed, %0d random records), %0d results checked",
             bytes_taken, dir_tbl.size(), records_sent, readings_seen);
    $display("idle mixes: none with a %0d-cycle output hold, sender, receiver, both sides",
             HoldLen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
